FILE: design/am_signal_generator_top_macros.svh
// Assertion macros used by the AM signal generator checker.
`ifndef AM_SIGNAL_GENERATOR_TOP_MACROS_SVH
`define AM_SIGNAL_GENERATOR_TOP_MACROS_SVH

// ante in one cycle implies cons in the next cycle
`define AMSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// ante implies cons in the same cycle
`define AMSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after reset is applied
`define AMSG_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

FILE: design/amsg_pkg.sv
// Shared types, constants and cosine table for the AM signal generator.
package amsg_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int LUT_ADDR_BITS      = 10;
  localparam int PHASE_BITS_DEFAULT = 32;
  localparam int STEP_BITS          = 32;
  localparam int MOD_INDEX_BITS     = 15;
  localparam int CFG_DATA_BITS      = 32;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int AM_BITS            = SAMPLE_BITS + 2;

  localparam int NUM_OSC     = 4;
  localparam int OSC_CARRIER = 0;
  localparam int OSC_TONE1   = 1;
  localparam int OSC_TONE2   = 2;
  localparam int OSC_TONE3   = 3;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [STEP_BITS-1:0]      CARRIER_STEP_RST = 32'd429496730;
  localparam logic [STEP_BITS-1:0]      TONE1_STEP_RST   = 32'd42949673;
  localparam logic [STEP_BITS-1:0]      TONE2_STEP_RST   = 32'd21474836;
  localparam logic [STEP_BITS-1:0]      TONE3_STEP_RST   = 32'd34359738;
  localparam logic [MOD_INDEX_BITS-1:0] MOD_INDEX_RST    = 15'd13107;

  localparam int QUARTER = 2 ** (LUT_ADDR_BITS - 2);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE         = 3'd0,
    REG_CARRIER_STEP = 3'd1,
    REG_TONE1_STEP   = 3'd2,
    REG_TONE2_STEP   = 3'd3,
    REG_TONE3_STEP   = 3'd4,
    REG_MOD_INDEX    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_OSC-1:0][STEP_BITS-1:0] step;
  } step_cfg_t;

  typedef struct packed {
    logic                      mode;
    logic [MOD_INDEX_BITS-1:0] mod_index;
  } back_cfg_t;

  typedef logic [NUM_OSC-1:0][LUT_ADDR_BITS-1:0] phase_addr_t;

  typedef logic [QUARTER:0][SAMPLE_BITS-2:0] qcos_tab_t;

  localparam logic [7:0] TAYLOR_DIV [1:7] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [63:0] HALF_Q30   = 64'd536870912;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] AMP_TOP    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // first-quadrant cosine, Taylor series to degree 14 in Q30
  function automatic qcos_tab_t build_qcos();
    qcos_tab_t          tab;
    logic [63:0]        u;
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        amp;
    logic signed [63:0] sum;
    tab = '0;
    for (int n = 0; n < QUARTER; n++) begin
      u     = 64'(n) << (32 - LUT_ADDR_BITS);
      theta = (u * HALFPI_Q30 + HALF_Q30) >> 30;
      t2    = (theta * theta + HALF_Q30) >> 30;
      term  = ONE_Q30;
      sum   = $signed(ONE_Q30);
      for (int k = 1; k <= 7; k++) begin
        term = (term * t2) >> 30;
        term = term / 64'(TAYLOR_DIV[k]);
        if ((k & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      amp = (($unsigned(sum) << (SAMPLE_BITS - 1)) + HALF_Q30) >> 30;
      if (amp > AMP_TOP) begin
        amp = AMP_TOP;
      end
      tab[n] = amp[SAMPLE_BITS-2:0];
    end
    return tab;
  endfunction

  localparam qcos_tab_t QCOS_TAB = build_qcos();
  localparam logic [LUT_ADDR_BITS-2:0] QTR_IDX = (LUT_ADDR_BITS-1)'(QUARTER);

  // full-wave cosine from the quarter table by quadrant symmetry
  function automatic logic signed [SAMPLE_BITS-1:0] table_cos(
    input logic [LUT_ADDR_BITS-1:0] addr
  );
    logic [1:0]                     quad;
    logic [LUT_ADDR_BITS-2:0]       idx;
    logic [SAMPLE_BITS-2:0]         mag;
    logic signed [SAMPLE_BITS-1:0]  val;
    quad = addr[LUT_ADDR_BITS-1 -: 2];
    idx  = {1'b0, addr[LUT_ADDR_BITS-3:0]};
    if (quad[0]) begin
      idx = QTR_IDX - idx;
    end
    mag = QCOS_TAB[idx];
    val = $signed({1'b0, mag});
    return (quad[0] ^ quad[1]) ? -val : val;
  endfunction

endpackage

FILE: design/amsg_front.sv
// Front end: accepts transactions, applies restart and steps the phase accumulators.
module amsg_front import amsg_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_restart,
  output logic        in_stall,
  input  step_cfg_t   steps,
  input  logic        q_full,
  output logic        push,
  output phase_addr_t push_data
);

  logic [NUM_OSC-1:0][PHASE_BITS-1:0] ph_r;
  logic [NUM_OSC-1:0][PHASE_BITS-1:0] ph_nxt;
  logic [NUM_OSC-1:0][PHASE_BITS-1:0] ph_cur;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < NUM_OSC; i++) begin
      ph_cur[i]    = in_restart ? '0 : ph_r[i];
      push_data[i] = ph_cur[i][PHASE_BITS-1 -: LUT_ADDR_BITS];
      ph_nxt[i]    = push ? ph_cur[i] + PHASE_BITS'(steps.step[i]) : ph_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
    end else begin
      ph_r <= ph_nxt;
    end
  end

endmodule

FILE: design/amsg_queue.sv
// Two-entry queue of table addresses between the front end and the datapath.
module amsg_queue import amsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  phase_addr_t push_data,
  input  logic        pop_req,
  output logic        full,
  output logic        valid,
  output phase_addr_t head
);

  phase_addr_t           entry_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r;
  logic [Q_PTR_BITS-1:0] wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r;
  logic [Q_PTR_BITS-1:0] rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] count_r;
  logic [Q_CNT_BITS-1:0] count_nxt;
  logic                  pop;

  assign full  = (count_r == Q_CNT_BITS'(Q_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];
  assign pop   = pop_req && valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/amsg_back.sv
// Datapath: table lookup, tone mix (mode 1) or tone 1 alone (mode 0), envelope and modulation, output register.
module amsg_back import amsg_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  back_cfg_t                     cfg,
  input  logic                          q_valid,
  input  phase_addr_t                   q_head,
  output logic                          pop_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [AM_BITS-1:0]     out_am_sample,
  output logic signed [SAMPLE_BITS-1:0] out_modulating_sample,
  output logic signed [SAMPLE_BITS-1:0] out_carrier_sample
);

  localparam int S        = SAMPLE_BITS;
  localparam int PW       = S + 15;
  localparam int SUM_W    = S + 16;
  localparam int ENV_W    = S + 16;
  localparam int PROD_W   = 2 * S + 16;
  localparam int AM_SHIFT = S + 13;

  localparam logic signed [PW-1:0]     WEIGHT_TONE2 = PW'(9830);
  localparam logic signed [PW-1:0]     WEIGHT_TONE3 = PW'(6554);
  localparam logic signed [SUM_W-1:0]  M_HALF       = SUM_W'(1) <<< 14;
  localparam logic signed [ENV_W-1:0]  ENV_ONE      = ENV_W'(1) <<< AM_SHIFT;
  localparam logic signed [PROD_W-1:0] AM_HALF      = PROD_W'(1) <<< (AM_SHIFT - 1);

  logic en;
  logic [5:1] v_r;
  logic [5:1] v_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  logic signed [S-1:0]      c1_r, t1_r, t2_r, t3_r;
  logic signed [S-1:0]      c1_nxt, t1_nxt, t2_nxt, t3_nxt;
  logic signed [S-1:0]      c2_r, m2_r;
  logic signed [PW-1:0]     p1_r, p2_r, p3_r;
  logic signed [PW-1:0]     p1_nxt, p2_nxt, p3_nxt;
  logic signed [S-1:0]      c3_r, m3_r, m3_nxt;
  logic signed [SUM_W-1:0]  sum3;
  logic signed [SUM_W-1:0]  m_rnd;
  logic signed [S-1:0]      c4_r, m4_r;
  logic signed [ENV_W-1:0]  env4_r, env4_nxt;
  logic signed [ENV_W-1:0]  mi_s;
  logic signed [S-1:0]      c5_r, m5_r;
  logic signed [PROD_W-1:0] prod5_r, prod5_nxt;
  logic signed [PROD_W-1:0] am_full;
  logic signed [AM_BITS-1:0] am_r, am_nxt;
  logic signed [S-1:0]      m_out_r, c_out_r;

  assign en      = !out_valid_r || !out_stall;
  assign pop_req = en;

  always_comb begin
    v_nxt         = {v_r[4:1], q_valid};
    out_valid_nxt = v_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    c1_nxt = table_cos(q_head[OSC_CARRIER]);
    t1_nxt = table_cos(q_head[OSC_TONE1]);
    t2_nxt = table_cos(q_head[OSC_TONE2]);
    t3_nxt = table_cos(q_head[OSC_TONE3]);
    p1_nxt = PW'(t1_r) <<< 14;
    p2_nxt = PW'(t2_r) * WEIGHT_TONE2;
    p3_nxt = PW'(t3_r) * WEIGHT_TONE3;
    sum3   = SUM_W'(p1_r) + SUM_W'(p2_r) + SUM_W'(p3_r);
    m_rnd  = (sum3 + M_HALF) >>> 15;
    m3_nxt = cfg.mode ? m_rnd[S-1:0] : m2_r;
    mi_s      = $signed({{(ENV_W - MOD_INDEX_BITS){1'b0}}, cfg.mod_index});
    env4_nxt  = ENV_ONE + mi_s * ENV_W'(m3_r);
    prod5_nxt = PROD_W'(env4_r) * PROD_W'(c4_r);
    am_full   = (prod5_r + AM_HALF) >>> AM_SHIFT;
    am_nxt    = am_full[AM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= c1_nxt;
      t1_r    <= t1_nxt;
      t2_r    <= t2_nxt;
      t3_r    <= t3_nxt;
      c2_r    <= c1_r;
      m2_r    <= t1_r;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      c3_r    <= c2_r;
      m3_r    <= m3_nxt;
      c4_r    <= c3_r;
      m4_r    <= m3_r;
      env4_r  <= env4_nxt;
      c5_r    <= c4_r;
      m5_r    <= m4_r;
      prod5_r <= prod5_nxt;
      am_r    <= am_nxt;
      m_out_r <= m5_r;
      c_out_r <= c5_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_am_sample         = am_r;
  assign out_modulating_sample = m_out_r;
  assign out_carrier_sample    = c_out_r;

endmodule

FILE: design/am_signal_generator_top.sv
// Top level of the AM signal generator: configuration registers and block wiring.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   in_restart
// out      out  out_valid / out_stall out_am_sample, out_modulating_sample, out_carrier_sample
// cfg      in   cfg_we                cfg_index, cfg_wdata
//
// One sample per clock cycle sustained while out_stall is low; every stage of the six-stage
// datapath takes a new transaction each unstalled cycle and the queue pops whenever the output
// is not stalled. An accepted input passes through the address queue to reach out_valid.
// Reset is synchronous: phases clear, the queue empties, registers take their defaults.
// out_stall freezes the datapath; two transactions queue before in_stall rises.
module am_signal_generator_top import amsg_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [AM_BITS-1:0]     out_am_sample,
  output logic signed [SAMPLE_BITS-1:0] out_modulating_sample,
  output logic signed [SAMPLE_BITS-1:0] out_carrier_sample,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata
);

  step_cfg_t   steps_r, steps_nxt;
  back_cfg_t   bcfg_r, bcfg_nxt;
  logic        q_full;
  logic        q_valid;
  logic        push;
  logic        pop_req;
  phase_addr_t push_data;
  phase_addr_t q_head;

  always_comb begin
    steps_nxt = steps_r;
    bcfg_nxt  = bcfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:         bcfg_nxt.mode                 = cfg_wdata[0];
        REG_CARRIER_STEP: steps_nxt.step[OSC_CARRIER]   = cfg_wdata[STEP_BITS-1:0];
        REG_TONE1_STEP:   steps_nxt.step[OSC_TONE1]     = cfg_wdata[STEP_BITS-1:0];
        REG_TONE2_STEP:   steps_nxt.step[OSC_TONE2]     = cfg_wdata[STEP_BITS-1:0];
        REG_TONE3_STEP:   steps_nxt.step[OSC_TONE3]     = cfg_wdata[STEP_BITS-1:0];
        REG_MOD_INDEX:    bcfg_nxt.mod_index            = cfg_wdata[MOD_INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r.step[OSC_CARRIER] <= CARRIER_STEP_RST;
      steps_r.step[OSC_TONE1]   <= TONE1_STEP_RST;
      steps_r.step[OSC_TONE2]   <= TONE2_STEP_RST;
      steps_r.step[OSC_TONE3]   <= TONE3_STEP_RST;
      bcfg_r.mode               <= 1'b0;
      bcfg_r.mod_index          <= MOD_INDEX_RST;
    end else begin
      steps_r <= steps_nxt;
      bcfg_r  <= bcfg_nxt;
    end
  end

  amsg_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_restart(in_restart),
    .in_stall  (in_stall),
    .steps     (steps_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  amsg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop_req  (pop_req),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  amsg_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (bcfg_r),
    .q_valid              (q_valid),
    .q_head               (q_head),
    .pop_req              (pop_req),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_am_sample        (out_am_sample),
    .out_modulating_sample(out_modulating_sample),
    .out_carrier_sample   (out_carrier_sample)
  );

endmodule

FILE: design/amsg_checker.sv
// Port-level assertions for the AM signal generator, bound to the top level.
`include "am_signal_generator_top_macros.svh"

module amsg_checker import amsg_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [AM_BITS-1:0]     out_am_sample,
  input logic signed [SAMPLE_BITS-1:0] out_modulating_sample,
  input logic signed [SAMPLE_BITS-1:0] out_carrier_sample
);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [AM_BITS-1:0]     AM_MAX     = (AM_BITS'(3) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [AM_BITS-1:0]     AM_MIN     = -AM_MAX;

  `AMSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_am_sample) && $stable(out_modulating_sample) && $stable(out_carrier_sample), "stalled output transaction changed")
  `AMSG_ASSERT_NOW(a_sample_sym, out_valid, out_carrier_sample != SAMPLE_MIN && out_modulating_sample != SAMPLE_MIN, "sample reached the most negative code")
  `AMSG_ASSERT_NOW(a_am_range, out_valid, out_am_sample <= AM_MAX && out_am_sample >= AM_MIN, "modulated sample out of range")
  `AMSG_ASSERT_RESET(a_reset_idle, !out_valid && !in_stall, "block not idle after reset")

endmodule

bind am_signal_generator_top amsg_checker u_amsg_checker (.*);
